// ===== rtl/hfas_pkg.sv =====
package hfas_pkg;

    localparam int HALF_W    = 16;
    localparam int EXP_W     = 5;
    localparam int FRAC_BITS = 10;
    localparam int MAG_W     = 12;
    localparam int SUM_W     = 13;
    localparam int EWIDE_W   = 7;

    localparam logic [HALF_W-1:0] SIGN_MASK  = 16'h8000;
    localparam logic [HALF_W-1:0] EXP_MASK   = 16'h7C00;
    localparam logic [HALF_W-1:0] FRAC_MASK  = 16'h03FF;
    localparam logic [HALF_W-1:0] HIDDEN_ONE = 16'h0400;

    localparam logic [EXP_W-1:0] EXP_MAX = 5'd31;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_SUB = 1'b1;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [EXP_W-1:0]        exp;
    } align_t;

    typedef struct packed {
        logic [HALF_W-1:0] result;
        logic              range_error;
    } result_t;

endpackage

// ===== rtl/hfas_in_if.sv =====
interface hfas_in_if;
    import hfas_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic [HALF_W-1:0] operand_a;
    logic [HALF_W-1:0] operand_b;

    modport source (output valid, output op, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input op, input operand_a, input operand_b,
                    output ready);
endinterface

// ===== rtl/hfas_out_if.sv =====
interface hfas_out_if;
    import hfas_pkg::*;

    logic              valid;
    logic              ready;
    logic [HALF_W-1:0] result;
    logic              range_error;

    modport source (output valid, output result, output range_error, input ready);
    modport sink   (input valid, input result, input range_error, output ready);
endinterface

// ===== rtl/half_float_add_sub.sv =====
// Half-precision adder/subtractor (1 sign, 5 exponent, 10 fraction bits).
// Channel "operands" (sink): op (0 add, 1 subtract), operand_a, operand_b.
// Channel "results" (source): result, range_error.
// A transfer happens on a rising clk edge with valid and ready both high.
// Operands go into an input register; alignment, add and normalization run
// combinationally into the result register. A transfer loads the input
// register, then the result register loads from it when free and offers it.
// Throughput: one item per cycle while the receiver keeps ready high.
// No denormals or specials; a zero sum gives +0, exponents outside 0..31
// saturate and set range_error. Fraction is truncated.
// Reset (rst_n low, asynchronous) empties both registers; nothing is offered.
// When the receiver holds ready low the result register holds, the input
// register still takes one more item if it is empty, and then operands.ready drops.
module half_float_add_sub (
    input  logic       clk,
    input  logic       rst_n,
    hfas_in_if.sink    operands,
    hfas_out_if.source results
);
    import hfas_pkg::*;

    logic              in_valid_reg;
    logic              op_reg;
    logic [HALF_W-1:0] a_reg;
    logic [HALF_W-1:0] b_reg;
    logic              out_valid_reg;
    result_t           res_reg;
    align_t            aligned;
    result_t           res_next;
    logic              out_free;
    logic              in_free;

    assign out_free = !out_valid_reg || results.ready;
    assign in_free  = !in_valid_reg || out_free;

    assign operands.ready      = in_free;
    assign results.valid       = out_valid_reg;
    assign results.result      = res_reg.result;
    assign results.range_error = res_reg.range_error;

    hfas_align_add u_align (
        .op        (op_reg),
        .operand_a (a_reg),
        .operand_b (b_reg),
        .aligned   (aligned)
    );

    hfas_normalize u_norm (
        .aligned (aligned),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_free)
            begin
                in_valid_reg <= operands.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_free && operands.valid)
        begin
            op_reg <= operands.op;
            a_reg  <= operands.operand_a;
            b_reg  <= operands.operand_b;
        end
        if (out_free && in_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

endmodule

// ===== rtl/hfas_align_add.sv =====
module hfas_align_add (
    input  logic                              op,
    input  logic [hfas_pkg::HALF_W-1:0]       operand_a,
    input  logic [hfas_pkg::HALF_W-1:0]       operand_b,
    output hfas_pkg::align_t                  aligned
);
    import hfas_pkg::*;

    logic [HALF_W-1:0]       b_eff;
    logic [EXP_W-1:0]        ea;
    logic [EXP_W-1:0]        eb;
    logic signed [MAG_W-1:0] ma;
    logic signed [MAG_W-1:0] mb;
    logic signed [MAG_W-1:0] va;
    logic signed [MAG_W-1:0] vb;

    always_comb
    begin
        b_eff = (op == OP_SUB) ? (operand_b ^ SIGN_MASK) : operand_b;
        ea = operand_a[HALF_W-2:FRAC_BITS];
        eb = b_eff[HALF_W-2:FRAC_BITS];
        ma = $signed(MAG_W'((operand_a & FRAC_MASK) | HIDDEN_ONE));
        mb = $signed(MAG_W'((b_eff & FRAC_MASK) | HIDDEN_ONE));
        va = operand_a[HALF_W-1] ? -ma : ma;
        vb = b_eff[HALF_W-1] ? -mb : mb;
        if (ea > eb)
        begin
            vb = vb >>> (ea - eb);
            aligned.exp = ea;
        end
        else
        begin
            va = va >>> (eb - ea);
            aligned.exp = eb;
        end
        aligned.sum = $signed({va[MAG_W-1], va}) + $signed({vb[MAG_W-1], vb});
    end

endmodule

// ===== rtl/hfas_normalize.sv =====
module hfas_normalize (
    input  hfas_pkg::align_t  aligned,
    output hfas_pkg::result_t res
);
    import hfas_pkg::*;

    logic                      sign;
    logic [SUM_W-1:0]          neg;
    logic [MAG_W-1:0]          mag;
    logic [3:0]                lead;
    logic [MAG_W-1:0]          shifted;
    logic [FRAC_BITS-1:0]      frac;
    logic signed [EWIDE_W-1:0] e_wide;
    logic [EXP_W-1:0]          e_sat;
    logic                      err;

    always_comb
    begin
        sign = aligned.sum[SUM_W-1];
        neg = -aligned.sum;
        mag = sign ? neg[MAG_W-1:0] : aligned.sum[MAG_W-1:0];
        lead = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (mag[i])
            begin
                lead = 4'(i);
            end
        end
        shifted = '0;
        if (lead == 4'(FRAC_BITS + 1))
        begin
            frac = mag[FRAC_BITS:1];
        end
        else
        begin
            shifted = mag << (4'(FRAC_BITS) - lead);
            frac = shifted[FRAC_BITS-1:0];
        end
        e_wide = $signed({2'b00, aligned.exp}) + $signed({3'b000, lead})
                 - EWIDE_W'(FRAC_BITS);
        err = 1'b0;
        if (e_wide < 0)
        begin
            e_sat = '0;
            err = 1'b1;
        end
        else if (e_wide > $signed({2'b00, EXP_MAX}))
        begin
            e_sat = EXP_MAX;
            err = 1'b1;
        end
        else
        begin
            e_sat = e_wide[EXP_W-1:0];
        end
        if (aligned.sum == '0)
        begin
            res.result = '0;
            res.range_error = 1'b0;
        end
        else
        begin
            res.result = {sign, e_sat, frac};
            res.range_error = err;
        end
    end

endmodule
